// File: hdl/pbss_pkg.sv
package pbss_pkg;

    localparam int POS_W       = 17;
    localparam int BDF_W       = 16;
    localparam int BUS_W       = 8;
    localparam int CFG_INDEX_W = 8;

    // Operation codes of an input item.
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_CONTINUE = 2'd1;
    localparam logic [1:0] OP_RESPONSE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ROOT_BUS_A = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ROOT_BUS_B = CFG_INDEX_W'(1);

    // Access sizes.
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    // Configuration space offsets.
    localparam logic [7:0] OFS_VENDOR  = 8'h00;
    localparam logic [7:0] OFS_HEADER  = 8'h0E;
    localparam logic [7:0] OFS_PRIMARY = 8'h18;

    localparam logic [31:0]      CFG_ENABLE  = 32'h8000_0000;
    localparam logic [POS_W-1:0] BUS_STRIDE  = POS_W'(17'h0_0100);
    localparam logic [15:0]      VENDOR_NONE = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_FOUND   = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MFUNC  = 3'd1,
        PH_VENDOR = 3'd2,
        PH_HDR    = 3'd3,
        PH_PRIM   = 3'd4,
        PH_FOUND  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] read_data;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] cfg_address;
        logic [1:0]  access_size;
        logic [1:0]  byte_lane;
        logic [15:0] found_bdf;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] limit;
        phase_t           phase;
        out_item_t        result;
    } seek_t;

    function automatic out_item_t plain_result(kind_t kind);
        out_item_t r;
        r             = '0;
        r.kind        = kind;
        return r;
    endfunction

    function automatic out_item_t read_request(logic [BDF_W-1:0] bdf, logic [7:0] ofs,
                                               logic [1:0] size);
        out_item_t r;
        r             = '0;
        r.kind        = KIND_READ;
        r.cfg_address = CFG_ENABLE | {8'h00, bdf, ofs & 8'hFC};
        r.access_size = size;
        case (size)
            SIZE_BYTE: r.byte_lane = ofs[1:0];
            SIZE_WORD: r.byte_lane = {ofs[1], 1'b0};
            default:   r.byte_lane = 2'd0;
        endcase
        return r;
    endfunction

    // Limit check with a jump to the extra root buses, then a vendor read or the end.
    function automatic seek_t seek(logic [POS_W-1:0] pos, logic [POS_W-1:0] limit,
                                   logic [BUS_W-1:0] bus_a, logic [BUS_W-1:0] bus_b);
        seek_t            s;
        logic [POS_W-1:0] ra;
        logic [POS_W-1:0] rb;
        logic             done;
        ra      = {1'b0, bus_a, 8'h00};
        rb      = {1'b0, bus_b, 8'h00};
        done    = 1'b0;
        s.pos   = pos;
        s.limit = limit;
        if (pos >= limit) begin
            if (bus_a != '0 && pos <= ra) begin
                s.pos = ra;
            end else if (bus_b != '0 && pos <= rb) begin
                s.pos = rb;
            end else begin
                done = 1'b1;
            end
            if (!done) begin
                s.limit = s.pos + BUS_STRIDE;
            end
        end
        if (done) begin
            s.phase  = PH_IDLE;
            s.result = plain_result(KIND_DONE);
        end else begin
            s.phase  = PH_VENDOR;
            s.result = read_request(s.pos[BDF_W-1:0], OFS_VENDOR, SIZE_WORD);
        end
        return s;
    endfunction

endpackage

// File: hdl/pci_bus_scan_sequencer.sv
// The result item of an accepted input item is held in the output register from the cycle after it is taken.
// Throughput: one item per cycle; the result register is the only stage between the two sides,
// and a new item is taken whenever that register is empty or being emptied.
// Reset: aresetn is synchronous and active low; it returns the scan to idle at position 0,
// the bus limit to 256 and both extra root buses to 0 (disabled).
module pci_bus_scan_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pbss_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pbss_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pbss_pkg::BUS_W-1:0]          cfg_wdata
);
    import pbss_pkg::*;

    logic [BUS_W-1:0] bus_a_reg;
    logic [BUS_W-1:0] bus_b_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] limit_reg, limit_next;
    phase_t           phase_reg, phase_next;
    logic [BDF_W-1:0] found_reg, found_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    out_item_t        result;
    logic             s_accept;

    logic             begin_req;
    logic [POS_W-1:0] begin_pos;
    logic             seek_req;
    logic [POS_W-1:0] seek_pos;
    logic [POS_W-1:0] seek_lim;
    logic [POS_W-1:0] prim_limit;
    logic [15:0]      vendor;
    logic [6:0]       hdr_type;
    seek_t            sk;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign vendor     = s_data.read_data[15:0];
    assign hdr_type   = s_data.read_data[6:0];
    assign prim_limit = {1'b0, s_data.read_data[15:8], 8'h00} + BUS_STRIDE;

    always_comb begin
        pos_next   = pos_reg;
        limit_next = limit_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        result     = plain_result(KIND_IGNORED);
        begin_req  = 1'b0;
        begin_pos  = '0;
        seek_req   = 1'b0;
        seek_pos   = pos_reg;
        seek_lim   = limit_reg;

        case (s_data.operation)
            OP_START: begin
                begin_req = 1'b1;
                seek_lim  = BUS_STRIDE;
            end
            OP_CONTINUE: begin
                if (phase_reg == PH_FOUND) begin
                    begin_req = 1'b1;
                    begin_pos = {1'b0, found_reg} + POS_W'(1);
                end
            end
            OP_RESPONSE: begin
                case (phase_reg)
                    PH_MFUNC: begin
                        // Single-function device: skip functions 1 to 7.
                        seek_pos = s_data.read_data[7] ? pos_reg : pos_reg + POS_W'(7);
                        seek_req = 1'b1;
                    end
                    PH_VENDOR: begin
                        if (vendor != 16'h0000 && vendor != VENDOR_NONE) begin
                            phase_next = PH_HDR;
                            result     = read_request(pos_reg[BDF_W-1:0], OFS_HEADER,
                                                      SIZE_BYTE);
                        end else begin
                            seek_pos = (pos_reg[2:0] == 3'd0) ? pos_reg + POS_W'(8)
                                                              : pos_reg + POS_W'(1);
                            seek_req = 1'b1;
                        end
                    end
                    PH_HDR: begin
                        if (hdr_type == 7'd1 || hdr_type == 7'd2) begin
                            phase_next = PH_PRIM;
                            result     = read_request(pos_reg[BDF_W-1:0], OFS_PRIMARY,
                                                      SIZE_DWORD);
                        end else begin
                            found_next       = pos_reg[BDF_W-1:0];
                            phase_next       = PH_FOUND;
                            result           = plain_result(KIND_FOUND);
                            result.found_bdf = pos_reg[BDF_W-1:0];
                        end
                    end
                    PH_PRIM: begin
                        if (prim_limit > limit_reg) begin
                            limit_next = prim_limit;
                        end
                        found_next       = pos_reg[BDF_W-1:0];
                        phase_next       = PH_FOUND;
                        result           = plain_result(KIND_FOUND);
                        result.found_bdf = pos_reg[BDF_W-1:0];
                    end
                    default: begin
                        result = plain_result(KIND_IGNORED);
                    end
                endcase
            end
            default: begin
                result = plain_result(KIND_IGNORED);
            end
        endcase

        if (begin_req) begin
            limit_next = seek_lim;
            if (begin_pos[2:0] == 3'd1) begin
                // Function 1 of a device: first check whether function 0 is multi-function.
                pos_next   = begin_pos;
                phase_next = PH_MFUNC;
                result     = read_request(begin_pos[BDF_W-1:0] - BDF_W'(1), OFS_HEADER,
                                          SIZE_BYTE);
            end else begin
                seek_req = 1'b1;
                seek_pos = begin_pos;
            end
        end

        sk = seek(seek_pos, seek_lim, bus_a_reg, bus_b_reg);
        if (seek_req) begin
            pos_next   = sk.pos;
            limit_next = sk.limit;
            phase_next = sk.phase;
            result     = sk.result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_a_reg   <= '0;
            bus_b_reg   <= '0;
            pos_reg     <= '0;
            limit_reg   <= BUS_STRIDE;
            phase_reg   <= PH_IDLE;
            found_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_EXTRA_ROOT_BUS_A) begin
                    bus_a_reg <= cfg_wdata;
                end else if (cfg_index == REG_EXTRA_ROOT_BUS_B) begin
                    bus_b_reg <= cfg_wdata;
                end
            end
            if (s_accept) begin
                pos_reg     <= pos_next;
                limit_reg   <= limit_next;
                phase_reg   <= phase_next;
                found_reg   <= found_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= result;
        end
    end

endmodule
